// File: hdl/error_diffusion_dither_defines.svh
// error_diffusion_dither_defines.svh: assertion macros for the dither rtl
// included by edd_ctrl and edd_dp, expects aclk and aresetn in scope
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EDD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("edd assertion failed");
`define EDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("edd assertion failed");
`else
`define EDD_ASSERT_SAME(label, ante, cons)
`define EDD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/edd_pkg.sv
// edd_pkg: shared widths, register indexes, reset values and command types
// for the error diffusion dither; no dependencies
`default_nettype none
package edd_pkg;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int LINE_WIDTH_BITS = 13;
    localparam int STEP_BITS       = 16;
    localparam int LEVEL_BITS      = 16;
    localparam int ERR_BITS        = 24;
    localparam int ACC_BITS        = 29;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_PIXEL_BITS  = 16;
    localparam int DEF_FRAC_BITS   = 4;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t CFG_LINE_WIDTH = 2'd0;
    localparam cfg_index_t CFG_STEP       = 2'd1;
    localparam cfg_index_t CFG_OUT_MAX    = 2'd2;

    localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 13'd256;
    localparam logic [STEP_BITS-1:0]       STEP_RESET       = 16'd255;
    localparam logic [LEVEL_BITS-1:0]      OUT_MAX_RESET    = 16'd1;

    typedef struct packed {
        logic accept;
        logic rd_left;
        logic rd_right;
        logic cap_ul;
        logic cap_up;
        logic acc;
        logic des;
        logic div_step;
        logic clamp;
        logic mul;
        logic err;
        logic finish;
    } edd_cmd_t;

    typedef struct packed {
        logic out_free;
    } edd_sts_t;

    // signed width of the rounded numerator
    function automatic int num_bits(int pb, int fb);
        int m;
        m = pb + fb + 1;
        if (ACC_BITS - 4 > m) m = ACC_BITS - 4;
        if (STEP_BITS + fb > m) m = STEP_BITS + fb;
        return m + 2;
    endfunction

    // quotient bits produced by the divider
    function automatic int quo_bits(int pb, int fb);
        return num_bits(pb, fb) - 1 - fb;
    endfunction

endpackage
`default_nettype wire

// File: hdl/edd_ctrl.sv
// edd_ctrl: sequencer for one pixel, reads, accumulate, divide, finish
// depends on edd_pkg and error_diffusion_dither_defines.svh
`default_nettype none
`include "error_diffusion_dither_defines.svh"
module edd_ctrl #(
    parameter int PIXEL_BITS      = edd_pkg::DEF_PIXEL_BITS,
    parameter int ERROR_FRAC_BITS = edd_pkg::DEF_FRAC_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    output edd_pkg::edd_cmd_t     cmd,
    input  wire edd_pkg::edd_sts_t sts
);
    import edd_pkg::*;

    localparam int QW   = quo_bits(PIXEL_BITS, ERROR_FRAC_BITS);
    localparam int CNTW = $clog2(QW);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RD_UL = 11'b000_0000_0010,
        ST_RD_UP = 11'b000_0000_0100,
        ST_RD_UR = 11'b000_0000_1000,
        ST_ACC   = 11'b000_0001_0000,
        ST_DES   = 11'b000_0010_0000,
        ST_DIV   = 11'b000_0100_0000,
        ST_CLAMP = 11'b000_1000_0000,
        ST_MUL   = 11'b001_0000_0000,
        ST_ERR   = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // a pending register write goes first
                if (in_valid && !cfg_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD_UL;
                end
            end
            ST_RD_UL: begin
                cmd.rd_left = 1'b1;
                state_next  = ST_RD_UP;
            end
            ST_RD_UP: begin
                cmd.cap_ul = 1'b1;
                state_next = ST_RD_UR;
            end
            ST_RD_UR: begin
                cmd.rd_right = 1'b1;
                cmd.cap_up   = 1'b1;
                state_next   = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_DES;
            end
            ST_DES: begin
                cmd.des    = 1'b1;
                cnt_next   = CNTW'(QW - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_CLAMP;
                end else begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd.err    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `EDD_ASSERT_NEXT(a_one_word_in_flight, in_valid && in_ready, !in_ready)
    `EDD_ASSERT_NEXT(a_fin_waits, (state_reg == ST_FIN) && !sts.out_free, state_reg == ST_FIN)
    `EDD_ASSERT_SAME(a_cnt_only_in_div, state_reg != ST_DIV, cnt_reg == '0)

endmodule
`default_nettype wire

// File: hdl/edd_dp.sv
// edd_dp: config registers, error line memory, accumulate, divider,
// error update and output register; depends on edd_pkg and the defines header
`default_nettype none
`include "error_diffusion_dither_defines.svh"
module edd_dp #(
    parameter int MAX_WIDTH       = edd_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS      = edd_pkg::DEF_PIXEL_BITS,
    parameter int ERROR_FRAC_BITS = edd_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire edd_pkg::edd_cmd_t                 cmd,
    output edd_pkg::edd_sts_t                      sts,
    input  wire logic [PIXEL_BITS-1:0]             s_pixel,
    input  wire logic                              s_frame_start,
    input  wire logic                              cfg_valid,
    input  wire edd_pkg::cfg_index_t               cfg_index,
    input  wire logic [edd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [edd_pkg::LEVEL_BITS-1:0]         m_out_level
);
    import edd_pkg::*;

    localparam int F    = ERROR_FRAC_BITS;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (AW + 1 > LINE_WIDTH_BITS) ? AW + 1 : LINE_WIDTH_BITS;
    localparam int UW   = STEP_BITS + F;
    localparam int DW   = num_bits(PIXEL_BITS, F);
    localparam int QW   = quo_bits(PIXEL_BITS, F);
    localparam int CW   = (QW > LEVEL_BITS) ? QW : LEVEL_BITS;
    localparam int PW   = LEVEL_BITS + UW;
    localparam int EW   = ((DW > PW + 1) ? DW : PW + 1) + 1;
    localparam logic signed [EW-1:0] E_MAX = EW'((2 ** (ERR_BITS - 1)) - 1);
    localparam logic signed [EW-1:0] E_MIN = ~E_MAX;

    // config registers
    logic [LINE_WIDTH_BITS-1:0] line_width_reg;
    logic [STEP_BITS-1:0]       step_reg;
    logic [LEVEL_BITS-1:0]      out_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RESET;
            step_reg       <= STEP_RESET;
            out_max_reg    <= OUT_MAX_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_data[LINE_WIDTH_BITS-1:0];
                CFG_STEP:       step_reg       <= cfg_data[STEP_BITS-1:0];
                CFG_OUT_MAX:    out_max_reg    <= cfg_data[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [CMPW-1:0]      lw_ext, width_eff;
    logic [STEP_BITS-1:0] step_eff;
    logic [UW-1:0]        unit;

    always_comb begin
        lw_ext = CMPW'(line_width_reg);
        priority if (lw_ext == '0) begin
            width_eff = CMPW'(1);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            width_eff = CMPW'(MAX_WIDTH);
        end else begin
            width_eff = lw_ext;
        end
        step_eff = (step_reg == '0) ? STEP_BITS'(1) : step_reg;
        unit     = {step_eff, {F{1'b0}}};
    end

    // row position and error history
    logic [AW-1:0]              col_reg;
    logic                       first_reg;
    logic signed [ERR_BITS-1:0] left_reg;
    logic                       last_reg;
    logic [PIXEL_BITS-1:0]      pix_reg;
    logic signed [ERR_BITS-1:0] rdata_reg, ul_reg, up_reg, e_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [DW-1:0]       desire_reg;
    logic                       neg_reg;
    logic [UW-1:0]              rem_reg;
    logic [QW-1:0]              n_reg, q_reg;
    logic [LEVEL_BITS-1:0]      lvl_reg;
    logic [PW-1:0]              prod_reg;
    logic                       m_valid_reg;
    logic [LEVEL_BITS-1:0]      m_out_level_reg;

    logic                       wrap_row, wrap, last_start;
    logic [AW-1:0]              col_start;

    always_comb begin
        wrap_row   = (CMPW'(col_reg) >= width_eff);
        wrap       = s_frame_start || wrap_row;
        col_start  = wrap ? '0 : col_reg;
        last_start = ((CMPW'(col_start) + CMPW'(1)) >= width_eff);
    end

    // error line memory, one read and one write port
    logic [ERR_BITS-1:0] mem [MAX_WIDTH];
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                wr_en;
    logic [ERR_BITS-1:0] wr_data;

    always_comb begin
        priority if (cmd.rd_left) begin
            rd_addr = col_reg - AW'(1);
        end else if (cmd.rd_right) begin
            rd_addr = col_reg + AW'(1);
        end else begin
            rd_addr = col_reg;
        end
        wr_en   = (cmd.err && (col_reg != '0)) || (cmd.finish && last_reg);
        wr_addr = cmd.err ? (col_reg - AW'(1)) : col_reg;
        wr_data = cmd.err ? left_reg : e_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // weighted error sum
    logic signed [ERR_BITS-1:0] lft, ur;
    logic signed [ACC_BITS-1:0] a_l, a_ul, a_up, a_ur, acc_sum;

    always_comb begin
        lft     = (col_reg == '0) ? '0 : left_reg;
        ur      = (first_reg || last_reg) ? '0 : rdata_reg;
        a_l     = ACC_BITS'(lft);
        a_ul    = ACC_BITS'(ul_reg);
        a_up    = ACC_BITS'(up_reg);
        a_ur    = ACC_BITS'(ur);
        acc_sum = (a_l <<< 3) - a_l + (a_ul <<< 1) + a_ul + (a_up <<< 2) + a_up + a_ur;
    end

    // desired value and rounded numerator
    logic [DW-1:0]        pix_ext, half;
    logic signed [DW-1:0] desire, num;

    always_comb begin
        pix_ext = DW'({pix_reg, {F{1'b0}}});
        half    = DW'({step_eff, {(F - 1){1'b0}}});
        desire  = $signed(pix_ext) + DW'($signed(acc_reg[ACC_BITS-1:4]));
        num     = desire + $signed(half);
    end

    // restoring divider, one quotient bit per cycle
    logic [UW:0]   trial, diff;
    logic          ge;
    logic [UW-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, n_reg[QW-1]};
        ge       = (trial >= {1'b0, unit});
        diff     = trial - {1'b0, unit};
        rem_next = ge ? diff[UW-1:0] : trial[UW-1:0];
    end

    // clamp and residual error
    logic [CW-1:0]              q_ext, om_ext;
    logic [LEVEL_BITS-1:0]      lvl_next;
    logic signed [EW-1:0]       e_full;
    logic signed [ERR_BITS-1:0] e_sat;

    always_comb begin
        q_ext  = CW'(q_reg);
        om_ext = CW'(out_max_reg);
        if (neg_reg) begin
            lvl_next = '0;
        end else if (q_ext > om_ext) begin
            lvl_next = out_max_reg;
        end else begin
            lvl_next = q_ext[LEVEL_BITS-1:0];
        end
        e_full = EW'(desire_reg) - $signed(EW'(prod_reg));
        priority if (e_full > E_MAX) begin
            e_sat = E_MAX[ERR_BITS-1:0];
        end else if (e_full < E_MIN) begin
            e_sat = E_MIN[ERR_BITS-1:0];
        end else begin
            e_sat = e_full[ERR_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            first_reg   <= 1'b1;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                col_reg   <= col_start;
                first_reg <= s_frame_start ? 1'b1 : (wrap_row ? 1'b0 : first_reg);
                if (wrap) begin
                    left_reg <= '0;
                end
            end
            if (cmd.finish) begin
                if (last_reg) begin
                    col_reg   <= '0;
                    first_reg <= 1'b0;
                    left_reg  <= '0;
                end else begin
                    col_reg  <= col_reg + AW'(1);
                    left_reg <= e_reg;
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg  <= s_pixel;
            last_reg <= last_start;
        end
        if (cmd.cap_ul) begin
            ul_reg <= (first_reg || (col_reg == '0)) ? '0 : rdata_reg;
        end
        if (cmd.cap_up) begin
            up_reg <= first_reg ? '0 : rdata_reg;
        end
        if (cmd.acc) begin
            acc_reg <= acc_sum;
        end
        if (cmd.des) begin
            desire_reg <= desire;
            neg_reg    <= num[DW-1];
            rem_reg    <= UW'(num[DW-2 -: F]);
            n_reg      <= num[QW-1:0];
            q_reg      <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            n_reg   <= {n_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], ge};
        end
        if (cmd.clamp) begin
            lvl_reg <= lvl_next;
        end
        if (cmd.mul) begin
            prod_reg <= PW'(lvl_reg) * PW'(unit);
        end
        if (cmd.err) begin
            e_reg <= e_sat;
        end
        if (cmd.finish) begin
            m_out_level_reg <= lvl_reg;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_out_level  = m_out_level_reg;

    `EDD_ASSERT_SAME(a_rem_below_unit, cmd.div_step, rem_reg < unit)
    `EDD_ASSERT_NEXT(a_level_clamped, cmd.finish, m_out_level <= out_max_reg)
    `EDD_ASSERT_NEXT(a_row_wrap, cmd.finish && last_reg, (col_reg == '0) && !first_reg)

endmodule
`default_nettype wire

// File: hdl/error_diffusion_dither.sv
// one pixel word is in flight at a time: s_ready returns only after the result
// is in the output register; QW = quotient bits (22 at default parameters) are made
// by the restoring divider, one bit a cycle; the result waits while the output is held
// reset: synchronous active low, clears control, row position, left error and
// config registers to their reset values; the error line memory is not cleared
`default_nettype none
module error_diffusion_dither #(
    parameter int MAX_WIDTH       = edd_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS      = edd_pkg::DEF_PIXEL_BITS,
    parameter int ERROR_FRAC_BITS = edd_pkg::DEF_FRAC_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [PIXEL_BITS-1:0]             s_pixel,
    input  wire logic                              s_frame_start,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [edd_pkg::LEVEL_BITS-1:0]         m_out_level,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire edd_pkg::cfg_index_t               cfg_index,
    input  wire logic [edd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import edd_pkg::*;

    edd_cmd_t cmd;
    edd_sts_t sts;

    edd_ctrl #(
        .PIXEL_BITS      (PIXEL_BITS),
        .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    edd_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .PIXEL_BITS      (PIXEL_BITS),
        .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_level   (m_out_level)
    );

endmodule
`default_nettype wire
